// ----- design/skt_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the streaming k-th largest tracker.
// Used by skt_cell, the top level, the checker and the testbench; depends on nothing.
package skt_pkg;

	localparam int VALUE_W  = 32;
	localparam int RANK_W   = 11;
	localparam int RANK_RST = 1024;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [RANK_W-1:0]         rank_t;

	// Broadcast to every cell: load on an accepted beat, and whether the store grows
	// (insert with shift towards the top) or replaces its smallest entry.
	typedef struct packed {
		logic load;
		logic grow;
	} cell_ctrl_t;

endpackage

// ----- design/streaming_kth_largest_tracker.sv -----
`timescale 1ns / 1ps
// Top level of the streaming k-th largest tracker: cell chain, count and output register.
// Depends on skt_pkg and skt_cell.
//
// The block keeps the largest rank values since the last start in a chain of MAX_RANK cells,
// sorted ascending so that the smallest held value always sits in the first cell. Every beat
// is compared against all cells at once and each cell either keeps its value, takes the new
// value or takes its neighbour's, so one beat is accepted in every cycle unless the output
// register holds a stalled result, and each result appears there in the next cycle.
// Occupancy is tracked by a count, so there is no clearing pass after reset or a rank write.
module streaming_kth_largest_tracker #(
	parameter int MAX_RANK = 1024
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [skt_pkg::RANK_W-1:0]    cfg_wr_data,  // rank
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [skt_pkg::VALUE_W-1:0]   s_tdata,      // [31:0] value
	input  logic                          s_tuser,      // [0] first
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [skt_pkg::VALUE_W-1:0]   m_tdata,      // [31:0] kth_value
	output logic                          m_tuser       // [0] full_res
);

	localparam int CNT_W    = $clog2(MAX_RANK + 1);
	localparam int EXT_W    = (CNT_W > skt_pkg::RANK_W) ? CNT_W : skt_pkg::RANK_W;
	localparam int RST_RANK = (MAX_RANK < skt_pkg::RANK_RST) ? MAX_RANK : skt_pkg::RANK_RST;

	logic [CNT_W-1:0]    rank_q;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_eff;
	logic [CNT_W-1:0]    count_nxt;
	logic [EXT_W-1:0]    rank_ext;
	logic [CNT_W-1:0]    rank_sat;
	logic                accept;
	skt_pkg::cell_ctrl_t ctrl;
	skt_pkg::value_t     key;
	skt_pkg::value_t     head_nxt;
	logic                m_tvalid_q;
	skt_pkg::value_t     kth_q;
	logic                full_q;

	logic            lt_w  [0:MAX_RANK+1];
	skt_pkg::value_t val_w [0:MAX_RANK+1];
	skt_pkg::value_t nxt_w [0:MAX_RANK-1];

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !m_tvalid_q || m_tready;
	assign key      = skt_pkg::value_t'(s_tdata);

	assign rank_ext = EXT_W'(cfg_wr_data);

	always_comb begin
		priority if (rank_ext == '0) begin
			rank_sat = CNT_W'(1);
		end else if (rank_ext > EXT_W'(MAX_RANK)) begin
			rank_sat = CNT_W'(MAX_RANK);
		end else begin
			rank_sat = rank_ext[CNT_W-1:0];
		end
	end

	always_comb begin
		priority if (s_tuser) begin
			count_eff = '0;
		end else if (count_q > rank_q) begin
			count_eff = rank_q;
		end else begin
			count_eff = count_q;
		end
		ctrl.load = accept;
		ctrl.grow = count_eff < rank_q;
		count_nxt = ctrl.grow ? count_eff + CNT_W'(1) : count_eff;
	end

	assign lt_w[0]           = 1'b1;
	assign val_w[0]          = '0;
	assign lt_w[MAX_RANK+1]  = 1'b0;
	assign val_w[MAX_RANK+1] = '0;

	for (genvar g = 0; g < MAX_RANK; g++) begin : g_cell
		skt_cell #(
			.CNT_W (CNT_W),
			.IDX   (g)
		) u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.count   (count_eff),
			.key     (key),
			.lt_prev (lt_w[g]),
			.v_prev  (val_w[g]),
			.lt_next (lt_w[g+2]),
			.v_next  (val_w[g+2]),
			.lt_self (lt_w[g+1]),
			.v_self  (val_w[g+1]),
			.nxt     (nxt_w[g])
		);
	end

	assign head_nxt = nxt_w[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rank_q     <= CNT_W'(RST_RANK);
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				rank_q  <= rank_sat;
				count_q <= '0;
			end else if (accept) begin
				count_q <= count_nxt;
			end
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kth_q  <= head_nxt;
			full_q <= count_nxt == rank_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = kth_q;
	assign m_tuser  = full_q;

endmodule

// ----- design/skt_cell.sv -----
`timescale 1ns / 1ps
// One cell of the ascending sorted store: holds one value and hands it to a neighbour.
// Depends on skt_pkg.
module skt_cell #(
	parameter int CNT_W = 11,
	parameter int IDX   = 0
) (
	input  logic                clk,
	input  skt_pkg::cell_ctrl_t ctrl,
	input  logic [CNT_W-1:0]    count,
	input  skt_pkg::value_t     key,
	input  logic                lt_prev,
	input  skt_pkg::value_t     v_prev,
	input  logic                lt_next,
	input  skt_pkg::value_t     v_next,
	output logic                lt_self,
	output skt_pkg::value_t     v_self,
	output skt_pkg::value_t     nxt
);

	skt_pkg::value_t v_q;
	logic            valid;

	assign valid   = CNT_W'(IDX) < count;
	assign lt_self = valid && (v_q < key);
	assign v_self  = v_q;

	always_comb begin
		if (ctrl.grow) begin
			priority if (lt_self) begin
				nxt = v_q;
			end else if (lt_prev) begin
				nxt = key;
			end else begin
				nxt = v_prev;
			end
		end else begin
			priority if (!lt_self) begin
				nxt = v_q;
			end else if (lt_next) begin
				nxt = v_next;
			end else begin
				nxt = key;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			v_q <= nxt;
		end
	end

endmodule

// ----- design/skt_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the streaming k-th largest tracker, bound to the top level.
// Depends on skt_pkg.
module skt_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_tvalid,
	input logic                        s_tready,
	input logic                        m_tvalid,
	input logic                        m_tready,
	input logic [skt_pkg::VALUE_W-1:0] m_tdata,
	input logic                        m_tuser
);

	// A stalled result beat keeps its payload.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result beat changed");

	// Every accepted input beat gives a result beat in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> m_tvalid)
		else $error("accepted beat produced no result");

	// No input beat is taken while an undelivered result is held.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input accepted while result stalled");

endmodule

bind streaming_kth_largest_tracker skt_checker u_skt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

// ----- dv/tb_streaming_kth_largest_tracker.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the streaming k-th largest tracker: directed table, then random
// value sets over several rank settings and idling mixes, each result beat checked against a
// top-k predictor or a pinned row. Depends on skt_pkg and streaming_kth_largest_tracker.
module tb_streaming_kth_largest_tracker;

	localparam int MAX_KEPT    = 1024;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 150;

	typedef enum logic {ROW_BEAT, ROW_RANK} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [31:0]      data;
		logic             first;
		logic             pinned;
		skt_pkg::value_t  kth;
		logic             full;
	} dir_row_t;

	typedef struct {
		skt_pkg::value_t kth;
		logic            full;
	} kth_result_t;

	typedef struct {
		int rank;
		int items;
		int src;
		int snk;
		bit pressure;
	} phase_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	skt_pkg::rank_t cfg_wr_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [skt_pkg::VALUE_W-1:0] s_tdata = '0;
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [skt_pkg::VALUE_W-1:0] m_tdata;
	logic m_tuser;

	logic beat_pinned = 1'b0;
	skt_pkg::value_t beat_pin_kth = '0;
	logic beat_pin_full = 1'b0;

	skt_pkg::value_t top_vals[$];
	skt_pkg::rank_t rank_reg = skt_pkg::rank_t'(skt_pkg::RANK_RST);
	kth_result_t kth_q[$];
	int err_cnt = 0;
	int src_pct = 0;
	int snk_pct = 0;
	int hold_req = 0;
	int hold_ack = 0;
	int hold_left = 0;
	int unsigned cycle_cnt = 0;

	dir_row_t dir_rows [29];
	phase_t phases [10];

	streaming_kth_largest_tracker #(
		.MAX_RANK(MAX_KEPT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #10 clk = ~clk;

	function automatic int kept_limit();
		if (rank_reg == 0)
			return 1;
		if (rank_reg > MAX_KEPT)
			return MAX_KEPT;
		return int'(rank_reg);
	endfunction

	// The kept values are held largest first; a new value goes after those greater than it.
	function automatic void track_value(input skt_pkg::value_t v, input logic first,
		output skt_pkg::value_t kth, output logic full);
		int lim;
		int pos;
		lim = kept_limit();
		if (first)
			top_vals.delete();
		if (top_vals.size() < lim || v > top_vals[lim-1]) begin
			if (top_vals.size() >= lim)
				void'(top_vals.pop_back());
			pos = 0;
			while (pos < top_vals.size() && top_vals[pos] > v)
				pos++;
			top_vals.insert(pos, v);
		end
		kth = top_vals[$];
		full = (top_vals.size() == lim);
	endfunction

	function automatic skt_pkg::value_t rand_value();
		case ($urandom_range(9))
			0, 1, 2: return skt_pkg::value_t'(int'($urandom_range(12)) - 6);
			3: begin
				case ($urandom_range(3))
					0: return 32'sh7FFF_FFFF;
					1: return 32'sh8000_0000;
					2: return '0;
					default: return '1;
				endcase
			end
			default: return skt_pkg::value_t'($urandom());
		endcase
	endfunction

	task automatic send_beat(input skt_pkg::value_t v, input logic first, input logic pin,
		input skt_pkg::value_t pin_kth, input logic pin_full);
		if (src_pct != 0 && $urandom_range(99) < src_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= v;
		s_tuser <= first;
		beat_pinned <= pin;
		beat_pin_kth <= pin_kth;
		beat_pin_full <= pin_full;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (kth_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_rank(input skt_pkg::rank_t r);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= r;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		rank_reg = r;
		top_vals.delete();
	endtask

	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else if (hold_req != hold_ack) begin
			hold_ack <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= snk_pct);
		end
	end

	always @(posedge clk) begin : track_and_check
		kth_result_t want;
		skt_pkg::value_t k;
		logic f;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (kth_q.size() == 0) begin
					$display("%0t: result beat with none expected, got kth %0d full %0b",
						$time, $signed(m_tdata), m_tuser);
					err_cnt++;
				end else begin
					want = kth_q.pop_front();
					if (m_tdata !== want.kth) begin
						$display("%0t: kth_value mismatch, expected %0d, got %0d",
							$time, want.kth, $signed(m_tdata));
						err_cnt++;
					end
					if (m_tuser !== want.full) begin
						$display("%0t: full_res mismatch, expected %0b, got %0b",
							$time, want.full, m_tuser);
						err_cnt++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				track_value(skt_pkg::value_t'(s_tdata), s_tuser, k, f);
				if (beat_pinned)
					kth_q.push_back('{beat_pin_kth, beat_pin_full});
				else
					kth_q.push_back('{k, f});
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int left;
		int lim;
		logic first;
		dir_rows = '{
			'{ROW_BEAT, 32'd5,           1'b1, 1'b1, 32'sd5,           1'b0},
			'{ROW_BEAT, 32'h7FFF_FFFF,   1'b0, 1'b1, 32'sd5,           1'b0},
			'{ROW_BEAT, 32'h8000_0000,   1'b0, 1'b1, 32'sh8000_0000,   1'b0},
			'{ROW_RANK, 32'd1,           1'b0, 1'b0, 32'sd0,           1'b0},
			'{ROW_BEAT, 32'hFFFF_FFFF,   1'b0, 1'b1, 32'shFFFF_FFFF,   1'b1},
			'{ROW_BEAT, 32'hFFFF_FFFF,   1'b0, 1'b1, 32'shFFFF_FFFF,   1'b1},
			'{ROW_BEAT, 32'hFFFF_FFFE,   1'b0, 1'b1, 32'shFFFF_FFFF,   1'b1},
			'{ROW_BEAT, 32'h7FFF_FFFF,   1'b0, 1'b1, 32'sh7FFF_FFFF,   1'b1},
			'{ROW_BEAT, 32'h8000_0000,   1'b1, 1'b1, 32'sh8000_0000,   1'b1},
			'{ROW_RANK, 32'd0,           1'b0, 1'b0, 32'sd0,           1'b0},
			'{ROW_BEAT, 32'd3,           1'b1, 1'b1, 32'sd3,           1'b1},
			'{ROW_BEAT, 32'd2,           1'b0, 1'b1, 32'sd3,           1'b1},
			'{ROW_RANK, 32'd3,           1'b0, 1'b0, 32'sd0,           1'b0},
			'{ROW_BEAT, 32'd10,          1'b1, 1'b0, 32'sd0,           1'b0},
			'{ROW_BEAT, 32'd30,          1'b0, 1'b0, 32'sd0,           1'b0},
			'{ROW_BEAT, 32'd20,          1'b0, 1'b0, 32'sd0,           1'b0},
			'{ROW_BEAT, 32'd20,          1'b0, 1'b0, 32'sd0,           1'b0},
			'{ROW_BEAT, 32'd25,          1'b0, 1'b0, 32'sd0,           1'b0},
			'{ROW_BEAT, 32'd10,          1'b0, 1'b0, 32'sd0,           1'b0},
			'{ROW_BEAT, 32'h7FFF_FFFF,   1'b0, 1'b0, 32'sd0,           1'b0},
			'{ROW_BEAT, 32'd4,           1'b1, 1'b0, 32'sd0,           1'b0},
			'{ROW_RANK, 32'd2047,        1'b0, 1'b0, 32'sd0,           1'b0},
			'{ROW_BEAT, 32'h7FFF_FFFF,   1'b0, 1'b1, 32'sh7FFF_FFFF,   1'b0},
			'{ROW_BEAT, 32'h8000_0000,   1'b0, 1'b1, 32'sh8000_0000,   1'b0},
			'{ROW_BEAT, 32'd0,           1'b0, 1'b0, 32'sd0,           1'b0},
			'{ROW_RANK, 32'd2,           1'b0, 1'b0, 32'sd0,           1'b0},
			'{ROW_BEAT, 32'hAAAA_AAAA,   1'b0, 1'b0, 32'sd0,           1'b0},
			'{ROW_BEAT, 32'h5555_5555,   1'b0, 1'b0, 32'sd0,           1'b0},
			'{ROW_BEAT, 32'h5555_5555,   1'b0, 1'b0, 32'sd0,           1'b0}
		};
		phases = '{
			'{2,    80,   0,  0,  1'b0},
			'{5,    100,  60, 0,  1'b0},
			'{1,    100,  0,  60, 1'b0},
			'{8,    100,  31, 31, 1'b0},
			'{0,    50,   31, 31, 1'b0},
			'{3,    150,  0,  0,  1'b1},
			'{16,   150,  31, 31, 1'b0},
			'{2047, 1030, 31, 31, 1'b0},
			'{1024, 60,   60, 0,  1'b0},
			'{37,   100,  0,  60, 1'b0}
		};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_RANK) begin
				drain_results();
				write_rank(skt_pkg::rank_t'(dir_rows[i].data));
			end else begin
				send_beat(skt_pkg::value_t'(dir_rows[i].data), dir_rows[i].first,
					dir_rows[i].pinned, dir_rows[i].kth, dir_rows[i].full);
			end
		end

		foreach (phases[p]) begin
			drain_results();
			write_rank(skt_pkg::rank_t'(phases[p].rank));
			src_pct = phases[p].src;
			snk_pct <= phases[p].snk;
			lim = kept_limit();
			left = 0;
			for (int n = 0; n < phases[p].items; n++) begin
				if (left == 0) begin
					if (lim >= 64)
						left = phases[p].items;
					else if ($urandom_range(3) == 0)
						left = $urandom_range(lim, 1);
					else
						left = $urandom_range(lim, 3 * lim + 2);
					first = 1'b1;
				end else begin
					first = 1'b0;
				end
				left--;
				send_beat(rand_value(), first, 1'b0, '0, 1'b0);
				if (phases[p].pressure) begin
					if (n % 50 == 25)
						hold_req <= hold_req + 1;
					if (n % 70 == 69)
						drain_results();
				end
			end
		end

		drain_results();
		repeat (16) @(posedge clk);
		if (err_cnt == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
